/* hw/rtl/fre_pkg.sv */
package fre_pkg;

   // field widths
   localparam int SampleWidth     = 16;
   localparam int LevelWidth      = 16;
   localparam int FrameCountWidth = 13;

   // longest frame that is accumulated
   localparam int MaxLength = 4096;

   localparam int CountWidth  = $clog2(MaxLength + 1);
   localparam int SquareWidth = 2 * SampleWidth;
   // each square is at most 2^30
   localparam int SumWidth    = 31 + $clog2(MaxLength);

   // mean square never exceeds 2^30, so 32 bits of quotient feed the root
   localparam int MeanWidth    = 32;
   localparam int RootSteps    = MeanWidth / 2;
   localparam int RootRemWidth = RootSteps + 2;

   localparam int StepWidth = $clog2(SumWidth);

   typedef enum logic [2:0] {
      ST_ACCUM,
      ST_FLUSH,
      ST_DIV_LOAD,
      ST_DIV,
      ST_ROOT_LOAD,
      ST_ROOT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic accept;
      logic div_load;
      logic div_step;
      logic root_load;
      logic root_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic frame_end;
      logic out_free;
   } status_type;

endpackage

/* hw/rtl/fre_if.sv */
interface fre_req_if;
   import fre_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [SampleWidth-1:0] sample;
   logic                          frame_end;

   modport source (output valid, output sample, output frame_end, input ready);
   modport sink   (input valid, input sample, input frame_end, output ready);
endinterface

interface fre_rsp_if;
   import fre_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [LevelWidth-1:0]      rms_level;
   logic [FrameCountWidth-1:0] frame_count;
   logic                       too_long;

   modport source (output valid, output rms_level, output frame_count,
                   output too_long, input ready);
   modport sink   (input valid, input rms_level, input frame_count,
                   input too_long, output ready);
endinterface

/* hw/rtl/fre_ctrl.sv */
module fre_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  fre_pkg::status_type status,
   output fre_pkg::cmd_type    cmd
);
   import fre_pkg::*;

   state_type              state_ff, state_in;
   logic [StepWidth-1:0]   step_ff, step_in;
   logic                   div_last;
   logic                   root_last;

   assign div_last  = step_ff == StepWidth'(SumWidth - 1);
   assign root_last = step_ff == StepWidth'(RootSteps - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACCUM;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_ACCUM: begin
            if (req_valid && status.frame_end) state_in = ST_FLUSH;
         end
         ST_FLUSH:     state_in = ST_DIV_LOAD;
         ST_DIV_LOAD:  state_in = ST_DIV;
         ST_DIV: begin
            if (div_last) state_in = ST_ROOT_LOAD;
         end
         ST_ROOT_LOAD: state_in = ST_ROOT;
         ST_ROOT: begin
            if (root_last) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (status.out_free) state_in = ST_ACCUM;
         end
         default:      state_in = ST_ACCUM;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      step_in   = '0;
      unique case (state_ff)
         ST_ACCUM: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_FLUSH: ;
         ST_DIV_LOAD:  cmd.div_load = 1'b1;
         ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
         end
         ST_ROOT_LOAD: cmd.root_load = 1'b1;
         ST_ROOT: begin
            cmd.root_step = 1'b1;
            step_in       = step_ff + 1'b1;
         end
         ST_DONE:      cmd.out_load = status.out_free;
         default: ;
      endcase
   end

endmodule

/* hw/rtl/fre_dp.sv */
module fre_dp (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic signed [fre_pkg::SampleWidth-1:0] req_sample,
   input  logic                                   req_frame_end,
   input  logic                                   rsp_ready,
   output logic                                   rsp_valid,
   output logic [fre_pkg::LevelWidth-1:0]         rsp_rms_level,
   output logic [fre_pkg::FrameCountWidth-1:0]    rsp_frame_count,
   output logic                                   rsp_too_long,
   input  fre_pkg::cmd_type                       cmd,
   output fre_pkg::status_type                    status
);
   import fre_pkg::*;

   // accumulation
   logic signed [SquareWidth-1:0] square;
   logic                          keep;
   logic [SquareWidth-1:0]        sq_ff;
   logic                          sq_valid_ff;
   logic [SumWidth-1:0]           sum_ff;
   logic [CountWidth-1:0]         count_ff;
   logic                          overflow_ff;

   // restoring divider
   logic [SumWidth-1:0]           div_quo_ff;
   logic [CountWidth-1:0]         div_rem_ff;
   logic [CountWidth-1:0]         div_divisor_ff;
   logic [CountWidth:0]           div_shift;
   logic [CountWidth:0]           div_diff;
   logic                          div_take;

   // digit-by-digit square root
   logic [MeanWidth-1:0]          root_rad_ff;
   logic [RootRemWidth-1:0]       root_rem_ff;
   logic [RootSteps-1:0]          root_ff;
   logic [RootRemWidth+1:0]       root_cand;
   logic [RootRemWidth+1:0]       root_trial;
   logic                          root_take;

   // result snapshot and output register
   logic [CountWidth-1:0]         res_count_ff;
   logic                          res_long_ff;
   logic                          rsp_valid_ff;
   logic [LevelWidth-1:0]         rsp_level_ff;
   logic [FrameCountWidth-1:0]    rsp_count_ff;
   logic                          rsp_long_ff;

   assign square = req_sample * req_sample;
   assign keep   = count_ff < CountWidth'(MaxLength);

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= 1'b0;
         sum_ff      <= '0;
         count_ff    <= '0;
         overflow_ff <= 1'b0;
      end else begin
         sq_valid_ff <= cmd.accept && keep;
         if (cmd.accept && keep) begin
            count_ff <= count_ff + 1'b1;
         end else if (cmd.accept) begin
            overflow_ff <= 1'b1;
         end
         if (sq_valid_ff) sum_ff <= sum_ff + SumWidth'(sq_ff);
         if (cmd.div_load) begin
            sum_ff      <= '0;
            count_ff    <= '0;
            overflow_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) sq_ff <= $unsigned(square);
   end

   assign div_shift = {div_rem_ff, div_quo_ff[SumWidth-1]};
   assign div_diff  = div_shift - {1'b0, div_divisor_ff};
   assign div_take  = div_shift >= {1'b0, div_divisor_ff};

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         div_quo_ff     <= sum_ff;
         div_rem_ff     <= '0;
         div_divisor_ff <= count_ff;
         res_count_ff   <= count_ff;
         res_long_ff    <= overflow_ff;
      end else if (cmd.div_step) begin
         div_quo_ff <= {div_quo_ff[SumWidth-2:0], div_take};
         div_rem_ff <= div_take ? div_diff[CountWidth-1:0] : div_shift[CountWidth-1:0];
      end
   end

   assign root_cand  = {root_rem_ff, root_rad_ff[MeanWidth-1 -: 2]};
   assign root_trial = (RootRemWidth + 2)'({root_ff, 2'b01});
   assign root_take  = root_cand >= root_trial;

   always_ff @(posedge clock) begin
      if (cmd.root_load) begin
         // empty frame: mean taken as zero
         root_rad_ff <= (div_divisor_ff == '0) ? '0 : div_quo_ff[MeanWidth-1:0];
         root_rem_ff <= '0;
         root_ff     <= '0;
      end else if (cmd.root_step) begin
         root_rad_ff <= {root_rad_ff[MeanWidth-3:0], 2'b00};
         root_rem_ff <= root_take ? RootRemWidth'(root_cand - root_trial)
                                  : root_cand[RootRemWidth-1:0];
         root_ff     <= {root_ff[RootSteps-2:0], root_take};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_level_ff <= LevelWidth'(root_ff);
         rsp_count_ff <= FrameCountWidth'(res_count_ff);
         rsp_long_ff  <= res_long_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_rms_level   = rsp_level_ff;
   assign rsp_frame_count = rsp_count_ff;
   assign rsp_too_long    = rsp_long_ff;

   assign status.frame_end = req_frame_end;
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

endmodule

/* hw/rtl/frame_rms_energy.sv */
// channel | dir | beat contents                          | taken when
// req_bus | in  | sample (s16 Q1.15), frame_end          | valid && ready
// rsp_bus | out | rms_level (u16 Q1.15), frame_count, too_long | valid && ready
//
// Sequence: samples are taken one per cycle while the block accumulates. A frame end
//   starts the back end: a flush to finish the pending add, a 43-step restoring divide
//   (one quotient bit per cycle), a 16-step square root (one root bit per cycle), loads
//   and the result load. No samples are taken until the back end is done.
// Reset: synchronous, clears accumulator, count, flags and the result valid.
// Stalls: the result waits in the output register while the next frame's
//   samples are taken; a second frame end holds in the done state until
//   that register is free.
module frame_rms_energy (
   input logic     clock,
   input logic     reset,
   fre_req_if.sink   req_bus,
   fre_rsp_if.source rsp_bus
);
   import fre_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       req_ready;

   // sequencer: accumulate, flush, divide, root, hand off
   fre_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // squarer, accumulator, divide and root units, result register
   fre_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_sample      (req_bus.sample),
      .req_frame_end   (req_bus.frame_end),
      .rsp_ready       (rsp_bus.ready),
      .rsp_valid       (rsp_bus.valid),
      .rsp_rms_level   (rsp_bus.rms_level),
      .rsp_frame_count (rsp_bus.frame_count),
      .rsp_too_long    (rsp_bus.too_long),
      .cmd             (cmd),
      .status          (status)
   );

   assign req_bus.ready = req_ready;

endmodule

/* hw/rtl/fre_checker.sv */
module fre_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                req_frame_end,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [fre_pkg::LevelWidth-1:0]      rsp_rms_level,
   input logic [fre_pkg::FrameCountWidth-1:0] rsp_frame_count,
   input logic                                rsp_too_long
);
   import fre_pkg::*;

   // a held result does not change
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_rms_level)
         && $stable(rsp_frame_count) && $stable(rsp_too_long))
      else $error("rsp beat changed while stalled");

   // a frame end beat puts the block into its busy back end
   a_busy_after_end: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_frame_end |=> !req_ready)
      else $error("req still ready after frame end");

   // a new result appears only out of the busy back end
   a_result_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result raised while sampling");

   // an over-long frame reports the full count
   a_long_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_too_long |-> rsp_frame_count == FrameCountWidth'(MaxLength))
      else $error("too_long with short count");

endmodule

bind frame_rms_energy fre_checker u_fre_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .req_frame_end   (req_bus.frame_end),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_rms_level   (rsp_bus.rms_level),
   .rsp_frame_count (rsp_bus.frame_count),
   .rsp_too_long    (rsp_bus.too_long)
);
